// ===== rtl/core/ihs_pkg.sv =====
// ----------------------------------------------------------------------------
// ihs_pkg
// Shared types, constants and functions of the id hash set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ihs_pkg;

  localparam int unsigned Slots   = 1024;
  localparam int unsigned SlotW   = $clog2(Slots);
  localparam int unsigned IdW     = 64;
  localparam int unsigned CountW  = 10;
  localparam int unsigned MinLog2 = 4;
  localparam logic [CountW-1:0] CountReset = CountW'(512);

  localparam logic FuncAdd  = 1'b0;
  localparam logic FuncTest = 1'b1;

  typedef struct packed {
    logic             func;
    logic [IdW-1:0]   id_hi;
    logic [IdW-1:0]   id_lo;
    logic [SlotW-1:0] bucket;
  } item_t;

  typedef struct packed {
    logic             none;
    logic [SlotW-1:0] mask;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic cfg_t ihs_cfg_of(logic [CountW-1:0] count);
    cfg_t             c;
    logic [CountW:0]  need;
    logic [SlotW:0]   cap;
    c.none = (count == '0);
    c.mask = SlotW'((1 << MinLog2) - 1);
    need   = {count, 1'b0};
    for (int i = 0; i < int'(SlotW - MinLog2); i++) begin
      cap = {1'b0, c.mask} + (SlotW + 1)'(1);
      if ((CountW + 1 > SlotW + 1 ? need > (CountW + 1)'(cap) : (SlotW + 1)'(need) > cap)
          && !(&c.mask)) begin
        c.mask = {c.mask[SlotW-2:0], 1'b1};
      end
    end
    return c;
  endfunction

  function automatic logic [SlotW-1:0] ihs_bucket(logic [IdW-1:0] hi, logic [IdW-1:0] lo);
    logic [SlotW-1:0]   h;
    logic [2*IdW-1:0]   id;
    h  = '0;
    id = {hi, lo};
    for (int i = 0; i < 2 * IdW; i++) begin
      h[i % SlotW] = h[i % SlotW] ^ id[i];
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ihs_front.sv =====
// ----------------------------------------------------------------------------
// ihs_front
// Accepts command words, computes the start bucket and hands them to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihs_front import ihs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output      logic             busy,
  input  wire logic             func_i,
  input  wire logic [IdW-1:0]   id_hi_i,
  input  wire logic [IdW-1:0]   id_lo_i,
  input  wire back_stat_t       back_stat_i,
  input  wire fifo_stat_t       fifo_stat_i,
  output      logic             push_o,
  output      item_t            item_o
);

  logic  vld_q, vld_d;
  item_t item_q;
  logic  accept;

  assign busy   = back_stat_i.clearing || (vld_q && fifo_stat_i.full);
  assign accept = start && !busy;
  assign push_o = vld_q && !fifo_stat_i.full;
  assign item_o = item_q;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.func   <= func_i;
      item_q.id_hi  <= id_hi_i;
      item_q.id_lo  <= id_lo_i;
      item_q.bucket <= ihs_bucket(id_hi_i, id_lo_i);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ihs_fifo.sv =====
// ----------------------------------------------------------------------------
// ihs_fifo
// Two-word queue between the front and the probe engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihs_fifo import ihs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire item_t      item_i,
  input  wire logic       pop_i,
  output      item_t      item_o,
  output      fifo_stat_t stat_o
);

  item_t      buf_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.full  = cnt_q[1];
  assign stat_o.empty = (cnt_q == 2'd0);
  assign item_o       = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ihs_back.sv =====
// ----------------------------------------------------------------------------
// ihs_back
// Probe engine: walks the slot memory, stores ids and issues results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ihs_back import ihs_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       clr_start_i,
  input  wire item_t      item_i,
  input  wire fifo_stat_t fifo_stat_i,
  output      back_stat_t stat_o,
  output      logic       done_o,
  output      logic       ok_o
);

  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StRead  = 4'b0100,
    StCmp   = 4'b1000
  } back_state_e;

  localparam int unsigned WordW = 2 * IdW + 1;

  back_state_e      state_q, state_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW-1:0] cnt_q, cnt_d;
  logic             func_q;
  logic [IdW-1:0]   hi_q, lo_q;
  logic             done_q, done_d, ok_q, ok_d;
  logic             pop;

  logic [WordW-1:0] mem_q [Slots];
  logic [WordW-1:0] rdata_q;
  logic             mem_we;
  logic [SlotW-1:0] mem_waddr;
  logic [WordW-1:0] mem_wdata;

  logic occ, match, hit;

  assign occ   = rdata_q[WordW-1];
  assign match = (rdata_q[2*IdW-1:IdW] == hi_q) && (rdata_q[IdW-1:0] == lo_q);
  assign hit   = !occ || match;

  assign pop             = (state_q == StIdle) && !fifo_stat_i.empty && !clr_start_i;
  assign stat_o.pop      = pop;
  assign stat_o.clearing = (state_q == StClear);
  assign done_o          = done_q;
  assign ok_o            = ok_q;

  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    ok_d      = ok_q;
    mem_we    = 1'b0;
    mem_waddr = slot_q;
    mem_wdata = {1'b1, hi_q, lo_q};
    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = '0;
        cnt_d     = cnt_q + SlotW'(1);
        if (&cnt_q) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (pop) begin
          cnt_d  = '0;
          slot_d = item_i.bucket & cfg_i.mask;
          if (cfg_i.none) begin
            done_d = 1'b1;
            ok_d   = 1'b0;
          end else begin
            state_d = StRead;
          end
        end
      end
      StRead: begin
        state_d = StCmp;
      end
      StCmp: begin
        if (hit) begin
          done_d  = 1'b1;
          state_d = StIdle;
          if (func_q == FuncAdd) begin
            mem_we = 1'b1;
            ok_d   = 1'b1;
          end else begin
            ok_d = occ;
          end
        end else if (cnt_q == cfg_i.mask) begin
          done_d  = 1'b1;
          ok_d    = 1'b0;
          state_d = StIdle;
        end else begin
          cnt_d   = cnt_q + SlotW'(1);
          slot_d  = (slot_q + SlotW'(1)) & cfg_i.mask;
          state_d = StRead;
        end
      end
      default: begin
        state_d = StClear;
      end
    endcase
    if (clr_start_i) begin
      state_d = StClear;
      cnt_d   = '0;
      done_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    ok_q   <= ok_d;
    if (pop) begin
      func_q <= item_i.func;
      hi_q   <= item_i.id_hi;
      lo_q   <= item_i.id_lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[slot_q];
  end

endmodule

`default_nettype wire

// ===== rtl/core/id_hash_set_linear_probe_top.sv =====
// ----------------------------------------------------------------------------
// id_hash_set_linear_probe_top
// Hash set of 128-bit ids, open addressing with linear probing.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; its result
// is valid on ok_o while done_o is high for one cycle, and results leave in
// command order. Each command is fetched from the queue; each visited slot
// then takes a registered read of the slot memory, then compare and store,
// while later commands wait in the queue. A miss in a full table visits
// every slot of the capacity. With expected_count zero the answer comes in
// the cycle after fetch, with ok_o low and no probe. After reset and after
// every write of expected_count the block clears the whole slot memory with busy high.
`timescale 1ns / 1ps
`default_nettype none

module id_hash_set_linear_probe_top import ihs_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output      logic              busy,
  input  wire logic              func_i,
  input  wire logic [IdW-1:0]    id_hi_i,
  input  wire logic [IdW-1:0]    id_lo_i,
  output      logic              done_o,
  output      logic              ok_o,
  input  wire logic              cfg_we_i,
  input  wire logic [CountW-1:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  back_stat_t back_stat;
  fifo_stat_t fifo_stat;
  logic       push;
  item_t      front_item, head_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ihs_cfg_of(CountReset);
    end else if (cfg_we_i) begin
      cfg_q <= ihs_cfg_of(cfg_wdata_i);
    end
  end

  ihs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .id_hi_i     (id_hi_i),
    .id_lo_i     (id_lo_i),
    .back_stat_i (back_stat),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .item_o      (front_item)
  );

  ihs_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (back_stat.pop),
    .item_o (head_item),
    .stat_o (fifo_stat)
  );

  ihs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clr_start_i (cfg_we_i),
    .item_i      (head_item),
    .fifo_stat_i (fifo_stat),
    .stat_o      (back_stat),
    .done_o      (done_o),
    .ok_o        (ok_o)
  );

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> busy)
    else $error("busy low after table clear started");

  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !cfg_q.none |=> !done_o)
    else $error("probe result on consecutive cycles");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.full && !back_stat.pop |-> !push)
    else $error("queue written while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.pop |-> !fifo_stat.empty && !back_stat.clearing)
    else $error("queue read while empty or clearing");

endmodule

`default_nettype wire
